FILE: src/bis_pkg.sv
// ----------------------------------------------------------------------------
// bis_pkg: shared types and constants of the bilinear image scaler
// Field widths, fixed-point formats, register codes, sequencer states and
// the control bundles passed between the scaler modules.
// ----------------------------------------------------------------------------
`default_nettype none

package bis_pkg;

  // Pixel format: three 8-bit channels, red in the low byte
  localparam int CHANNELS   = 3;
  localparam int CH_W       = 8;
  localparam int PIX_W      = CHANNELS * CH_W;

  // Request fields and configuration register widths
  localparam int COL_W      = 9;
  localparam int ROW_W      = 9;
  localparam int SIZE_W     = 10;
  localparam int STEP_W     = 25;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 25;

  // Fixed-point formats of the position and blend datapath
  localparam int FRAC_W     = 16;
  localparam int POS_W      = COL_W + STEP_W;
  localparam int INT_W      = POS_W - FRAC_W;
  localparam int WT_W       = FRAC_W + 1;
  localparam int HBL_W      = CH_W + FRAC_W;
  localparam int VBL_W      = HBL_W + WT_W;

  localparam logic [CH_W-1:0] BYTE_MASK = 8'hFF;
  localparam logic [WT_W-1:0] ONE_Q16   = 17'h10000;

  // Reset values of the configuration registers
  localparam logic [SIZE_W-1:0] SIZE_RESET = 10'd512;
  localparam logic [STEP_W-1:0] STEP_RESET = 25'd65536;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SRC_WIDTH  = 4'd0,
    CFG_SRC_HEIGHT = 4'd1,
    CFG_X_STEP     = 4'd2,
    CFG_Y_STEP     = 4'd3
  } cfg_reg_t;

  typedef enum logic {
    REQ_WRITE  = 1'b0,
    REQ_INTERP = 1'b1
  } req_type_t;

  // Neighbor select: bit 0 picks the right column, bit 1 the bottom row
  typedef enum logic [1:0] {
    TAP_TL = 2'd0,
    TAP_TR = 2'd1,
    TAP_BL = 2'd2,
    TAP_BR = 2'd3
  } tap_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL,
    S_CLAMP,
    S_RD0,
    S_RD1,
    S_RD2,
    S_RD3,
    S_H1,
    S_V,
    S_OUT
  } state_t;

  // Pixel store port control
  typedef struct packed {
    logic en;
    logic we;
  } pmem_ctl_t;

  // Sequencer outputs to the datapath
  typedef struct packed {
    logic in_ready;
    logic mem_rd;
    tap_t tap_sel;
    logic cap_pos;
    logic cap_clamp;
    logic cap_tap;
    logic cap_h0;
    logic cap_h1;
    logic cap_res;
    logic load_out;
  } seq_ctl_t;

endpackage

`default_nettype wire

FILE: src/bis_in_if.sv
// ----------------------------------------------------------------------------
// bis_in_if: input request channel of the bilinear image scaler
// Carries pixel writes and interpolation requests with a valid/ready pair.
// ----------------------------------------------------------------------------
`default_nettype none

interface bis_in_if;
  logic                     valid;
  logic                     ready;
  logic                     req_type;
  logic [bis_pkg::COL_W-1:0] col;
  logic [bis_pkg::ROW_W-1:0] row;
  logic [bis_pkg::CH_W-1:0]  red_in;
  logic [bis_pkg::CH_W-1:0]  green_in;
  logic [bis_pkg::CH_W-1:0]  blue_in;

  modport source (
    output valid, req_type, col, row, red_in, green_in, blue_in,
    input  ready
  );

  modport sink (
    input  valid, req_type, col, row, red_in, green_in, blue_in,
    output ready
  );
endinterface

`default_nettype wire

FILE: src/bis_out_if.sv
// ----------------------------------------------------------------------------
// bis_out_if: result channel of the bilinear image scaler
// Carries one interpolated pixel and its edge flag with a valid/ready pair.
// ----------------------------------------------------------------------------
`default_nettype none

interface bis_out_if;
  logic                    valid;
  logic                    ready;
  logic [bis_pkg::CH_W-1:0] red_out;
  logic [bis_pkg::CH_W-1:0] green_out;
  logic [bis_pkg::CH_W-1:0] blue_out;
  logic                    edge_clamped;

  modport source (
    output valid, red_out, green_out, blue_out, edge_clamped,
    input  ready
  );

  modport sink (
    input  valid, red_out, green_out, blue_out, edge_clamped,
    output ready
  );
endinterface

`default_nettype wire

FILE: src/bis_cfg_if.sv
// ----------------------------------------------------------------------------
// bis_cfg_if: configuration write channel of the bilinear image scaler
// Carries a register index and write data with a valid/ready pair.
// ----------------------------------------------------------------------------
`default_nettype none

interface bis_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [bis_pkg::CFG_IDX_W-1:0]  index;
  logic [bis_pkg::CFG_DATA_W-1:0] data;

  modport source (
    output valid, index, data,
    input  ready
  );

  modport sink (
    input  valid, index, data,
    output ready
  );
endinterface

`default_nettype wire

FILE: src/bilinear_image_scaler_unit.sv
// ----------------------------------------------------------------------------
// bilinear_image_scaler_unit: bilinear resize of a stored RGB source image
// Pixel store, position multiply, edge clamp and two-pass channel blend.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries requests. A write request (req_type 0) stores one source
//   pixel at (col,row); writes are taken one per cycle while idle and produce
//   no result. An interpolation request (req_type 1) names a target pixel; its
//   result appears on out_ch after the steps MUL, CLAMP, RD0 to RD3, H1, V and
//   OUT. The block takes the next request when the sequencer is back in idle,
//   so the sequencer works on one request at a time: the four neighbors are
//   read one after the other through the single port of the pixel store,
//   behind a registered position multiply and an edge-clamp stage, then
//   blended in two passes. The result sits in an output register; while the
//   receiver stalls, the block still accepts writes and one further request,
//   which then waits in its last step until the output register frees.
//   cfg_ch, always ready, writes source_width, source_height, x_step and
//   y_step (indexes 0..3, others ignored); the user must write it while idle;
//   the block does not enforce this. Reset (rst_n low, synchronous) restores
//   the register defaults and empties the output register; the pixel store is
//   not cleared, so a pixel must be written before any request reads it.
// ----------------------------------------------------------------------------
`default_nettype none

module bilinear_image_scaler_unit #(
  parameter int MAX_WIDTH  = 512,
  parameter int MAX_HEIGHT = 512
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  bis_in_if.sink     in_ch,
  bis_out_if.source  out_ch,
  bis_cfg_if.sink    cfg_ch
);

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(DEPTH);
  localparam int XW    = $clog2(MAX_WIDTH);
  localparam int YW    = $clog2(MAX_HEIGHT);

  localparam int CHN   = bis_pkg::CHANNELS;
  localparam int CH_W  = bis_pkg::CH_W;
  localparam int PIX_W = bis_pkg::PIX_W;
  localparam int POS_W = bis_pkg::POS_W;
  localparam int INT_W = bis_pkg::INT_W;
  localparam int FRAC_W = bis_pkg::FRAC_W;
  localparam int WT_W  = bis_pkg::WT_W;
  localparam int HBL_W = bis_pkg::HBL_W;
  localparam int VBL_W = bis_pkg::VBL_W;

  // Last valid coordinate for a configured size, clamped to [1, maxv-1]
  function automatic logic [31:0] last_of(logic [bis_pkg::SIZE_W-1:0] v, int maxv);
    logic [31:0] ext;
    ext = 32'(v);
    if (ext < 32'd2) begin
      return 32'd1;
    end else if (ext > 32'(maxv)) begin
      return 32'(maxv - 1);
    end
    return ext - 32'd1;
  endfunction

  // Horizontal blend of two channel bytes with complementary weights
  function automatic logic [HBL_W-1:0] blend_h(logic [CH_W-1:0] p0, logic [CH_W-1:0] p1,
                                              logic [WT_W-1:0] wn, logic [WT_W-1:0] w);
    logic [HBL_W:0] s;
    s = ({{WT_W{1'b0}}, p0} * {{CH_W{1'b0}}, wn}) + ({{WT_W{1'b0}}, p1} * {{CH_W{1'b0}}, w});
    return s[HBL_W-1:0];
  endfunction

  // Vertical blend of two row sums; keep the integer byte of the Q32 result
  function automatic logic [CH_W-1:0] blend_v(logic [HBL_W-1:0] h0, logic [HBL_W-1:0] h1,
                                             logic [WT_W-1:0] wn, logic [WT_W-1:0] w);
    logic [VBL_W-1:0] s;
    s = ({{WT_W{1'b0}}, h0} * {{HBL_W{1'b0}}, wn}) + ({{WT_W{1'b0}}, h1} * {{HBL_W{1'b0}}, w});
    return s[2*FRAC_W +: CH_W] & bis_pkg::BYTE_MASK;
  endfunction

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [bis_pkg::SIZE_W-1:0] src_width_r;
  logic [bis_pkg::SIZE_W-1:0] src_height_r;
  logic [bis_pkg::STEP_W-1:0] x_step_r;
  logic [bis_pkg::STEP_W-1:0] y_step_r;

  assign cfg_ch.ready = 1'b1;

  // Write the indexed register; drop unknown indexes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_width_r  <= bis_pkg::SIZE_RESET;
      src_height_r <= bis_pkg::SIZE_RESET;
      x_step_r     <= bis_pkg::STEP_RESET;
      y_step_r     <= bis_pkg::STEP_RESET;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        bis_pkg::CFG_SRC_WIDTH:  src_width_r  <= cfg_ch.data[bis_pkg::SIZE_W-1:0];
        bis_pkg::CFG_SRC_HEIGHT: src_height_r <= cfg_ch.data[bis_pkg::SIZE_W-1:0];
        bis_pkg::CFG_X_STEP:     x_step_r     <= cfg_ch.data[bis_pkg::STEP_W-1:0];
        bis_pkg::CFG_Y_STEP:     y_step_r     <= cfg_ch.data[bis_pkg::STEP_W-1:0];
        default: ;
      endcase
    end
  end

  logic [XW-1:0] wlast;
  logic [YW-1:0] hlast;

  assign wlast = XW'(last_of(src_width_r, MAX_WIDTH));
  assign hlast = YW'(last_of(src_height_r, MAX_HEIGHT));

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  bis_pkg::state_t   state_r;
  bis_pkg::state_t   state_nxt;
  bis_pkg::seq_ctl_t ctl;
  logic              out_valid_r;
  logic              in_take;
  logic              req_take;

  assign in_take  = in_ch.valid && ctl.in_ready;
  assign req_take = in_take && (in_ch.req_type == bis_pkg::REQ_INTERP);

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      bis_pkg::S_IDLE:  if (req_take) state_nxt = bis_pkg::S_MUL;
      bis_pkg::S_MUL:   state_nxt = bis_pkg::S_CLAMP;
      bis_pkg::S_CLAMP: state_nxt = bis_pkg::S_RD0;
      bis_pkg::S_RD0:   state_nxt = bis_pkg::S_RD1;
      bis_pkg::S_RD1:   state_nxt = bis_pkg::S_RD2;
      bis_pkg::S_RD2:   state_nxt = bis_pkg::S_RD3;
      bis_pkg::S_RD3:   state_nxt = bis_pkg::S_H1;
      bis_pkg::S_H1:    state_nxt = bis_pkg::S_V;
      bis_pkg::S_V:     state_nxt = bis_pkg::S_OUT;
      bis_pkg::S_OUT:   if (!out_valid_r || out_ch.ready) state_nxt = bis_pkg::S_IDLE;
      default:          state_nxt = bis_pkg::S_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    ctl = '0;
    ctl.tap_sel = bis_pkg::TAP_TL;
    unique case (state_r)
      bis_pkg::S_IDLE:  ctl.in_ready = 1'b1;
      bis_pkg::S_MUL:   ctl.cap_pos = 1'b1;
      bis_pkg::S_CLAMP: ctl.cap_clamp = 1'b1;
      bis_pkg::S_RD0: begin
        ctl.mem_rd  = 1'b1;
        ctl.tap_sel = bis_pkg::TAP_TL;
      end
      bis_pkg::S_RD1: begin
        ctl.mem_rd  = 1'b1;
        ctl.tap_sel = bis_pkg::TAP_TR;
        ctl.cap_tap = 1'b1;
      end
      bis_pkg::S_RD2: begin
        ctl.mem_rd  = 1'b1;
        ctl.tap_sel = bis_pkg::TAP_BL;
        ctl.cap_h0  = 1'b1;
      end
      bis_pkg::S_RD3: begin
        ctl.mem_rd  = 1'b1;
        ctl.tap_sel = bis_pkg::TAP_BR;
        ctl.cap_tap = 1'b1;
      end
      bis_pkg::S_H1:    ctl.cap_h1 = 1'b1;
      bis_pkg::S_V:     ctl.cap_res = 1'b1;
      bis_pkg::S_OUT:   ctl.load_out = !out_valid_r || out_ch.ready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bis_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ch.ready = ctl.in_ready;

  // ---------------------------------------------------------------------------
  // Position and clamp
  // ---------------------------------------------------------------------------
  logic [bis_pkg::COL_W-1:0] col_r;
  logic [bis_pkg::ROW_W-1:0] row_r;
  logic [POS_W-1:0]          pos_x_r;
  logic [POS_W-1:0]          pos_y_r;
  logic [XW-1:0]             x0_r;
  logic [XW-1:0]             x1_r;
  logic [YW-1:0]             y0_r;
  logic [YW-1:0]             y1_r;
  logic [FRAC_W-1:0]         wx_r;
  logic [FRAC_W-1:0]         wy_r;
  logic                      flag_r;

  logic [INT_W:0] xi;
  logic [INT_W:0] xi1;
  logic [INT_W:0] yi;
  logic [INT_W:0] yi1;
  logic           cx0;
  logic           cx1;
  logic           cy0;
  logic           cy1;

  assign xi  = {1'b0, pos_x_r[POS_W-1:FRAC_W]};
  assign yi  = {1'b0, pos_y_r[POS_W-1:FRAC_W]};
  assign xi1 = xi + (INT_W+1)'(1);
  assign yi1 = yi + (INT_W+1)'(1);
  assign cx0 = xi  > (INT_W+1)'(wlast);
  assign cx1 = xi1 > (INT_W+1)'(wlast);
  assign cy0 = yi  > (INT_W+1)'(hlast);
  assign cy1 = yi1 > (INT_W+1)'(hlast);

  // Hold the target, multiply by the steps, then clamp the neighbors
  always_ff @(posedge clk) begin
    if (req_take) begin
      col_r <= in_ch.col;
      row_r <= in_ch.row;
    end
    if (ctl.cap_pos) begin
      pos_x_r <= {{bis_pkg::STEP_W{1'b0}}, col_r} * {{bis_pkg::COL_W{1'b0}}, x_step_r};
      pos_y_r <= {{bis_pkg::STEP_W{1'b0}}, row_r} * {{bis_pkg::ROW_W{1'b0}}, y_step_r};
    end
    if (ctl.cap_clamp) begin
      x0_r   <= cx0 ? wlast : xi[XW-1:0];
      x1_r   <= cx1 ? wlast : xi1[XW-1:0];
      y0_r   <= cy0 ? hlast : yi[YW-1:0];
      y1_r   <= cy1 ? hlast : yi1[YW-1:0];
      wx_r   <= pos_x_r[FRAC_W-1:0];
      wy_r   <= pos_y_r[FRAC_W-1:0];
      flag_r <= cx0 || cx1 || cy0 || cy1;
    end
  end

  // ---------------------------------------------------------------------------
  // Pixel store access
  // ---------------------------------------------------------------------------
  bis_pkg::pmem_ctl_t mem_ctl;
  logic [AW-1:0]      mem_addr;
  logic [AW-1:0]      wr_addr;
  logic [AW-1:0]      rd_addr;
  logic [PIX_W-1:0]   mem_rdata;
  logic               wr_go;
  logic               wr_in_range;
  logic [XW-1:0]      rx;
  logic [YW-1:0]      ry;

  assign wr_in_range = (32'(in_ch.col) < 32'(MAX_WIDTH)) && (32'(in_ch.row) < 32'(MAX_HEIGHT));
  assign wr_go       = in_take && (in_ch.req_type == bis_pkg::REQ_WRITE) && wr_in_range;
  assign wr_addr     = AW'(32'(in_ch.row) * 32'(MAX_WIDTH) + 32'(in_ch.col));

  assign rx = (ctl.tap_sel == bis_pkg::TAP_TR || ctl.tap_sel == bis_pkg::TAP_BR) ? x1_r : x0_r;
  assign ry = (ctl.tap_sel == bis_pkg::TAP_BL || ctl.tap_sel == bis_pkg::TAP_BR) ? y1_r : y0_r;
  assign rd_addr = AW'(32'(ry) * 32'(MAX_WIDTH) + 32'(rx));

  assign mem_ctl.en = wr_go || ctl.mem_rd;
  assign mem_ctl.we = wr_go;
  assign mem_addr   = wr_go ? wr_addr : rd_addr;

  bis_pixel_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .ctl   (mem_ctl),
    .addr  (mem_addr),
    .wdata ({in_ch.blue_in, in_ch.green_in, in_ch.red_in}),
    .rdata (mem_rdata)
  );

  // ---------------------------------------------------------------------------
  // Blend datapath
  // ---------------------------------------------------------------------------
  logic [PIX_W-1:0]               tap_r;
  logic [CHN-1:0][HBL_W-1:0]      h_cur;
  logic [CHN-1:0][HBL_W-1:0]      h0_r;
  logic [CHN-1:0][HBL_W-1:0]      h1_r;
  logic [CHN-1:0][CH_W-1:0]       res_cur;
  logic [CHN-1:0][CH_W-1:0]       res_r;
  logic [WT_W-1:0]                wx;
  logic [WT_W-1:0]                wxn;
  logic [WT_W-1:0]                wy;
  logic [WT_W-1:0]                wyn;

  assign wx  = {1'b0, wx_r};
  assign wy  = {1'b0, wy_r};
  assign wxn = bis_pkg::ONE_Q16 - wx;
  assign wyn = bis_pkg::ONE_Q16 - wy;

  // Blend the held left tap with the arriving right tap, then the two rows
  always_comb begin
    for (int c = 0; c < CHN; c++) begin
      h_cur[c]   = blend_h(tap_r[c*CH_W +: CH_W], mem_rdata[c*CH_W +: CH_W], wxn, wx);
      res_cur[c] = blend_v(h0_r[c], h1_r[c], wyn, wy);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.cap_tap) begin
      tap_r <= mem_rdata;
    end
    if (ctl.cap_h0) begin
      h0_r <= h_cur;
    end
    if (ctl.cap_h1) begin
      h1_r <= h_cur;
    end
    if (ctl.cap_res) begin
      res_r <= res_cur;
    end
  end

  // ---------------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------------
  logic [CHN-1:0][CH_W-1:0] out_px_r;
  logic                     out_edge_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_out) begin
      out_px_r   <= res_r;
      out_edge_r <= flag_r;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.red_out      = out_px_r[0];
  assign out_ch.green_out    = out_px_r[1];
  assign out_ch.blue_out     = out_px_r[2];
  assign out_ch.edge_clamped = out_edge_r;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_write_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    mem_ctl.we |-> (state_r == bis_pkg::S_IDLE && !ctl.mem_rd))
    else $error("pixel store write outside idle");

  a_request_starts: assert property (@(posedge clk) disable iff (!rst_n)
    req_take |=> (state_r == bis_pkg::S_MUL && !in_ch.ready))
    else $error("accepted request did not start the sequencer");

  a_unclamped_adjacent: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == bis_pkg::S_RD0 && !flag_r) |->
      ((XW+1)'(x1_r) == (XW+1)'(x0_r) + (XW+1)'(1) &&
       (YW+1)'(y1_r) == (YW+1)'(y0_r) + (YW+1)'(1)))
    else $error("unclamped neighbors are not adjacent");

endmodule

`default_nettype wire

FILE: src/bis_pixel_mem.sv
// ----------------------------------------------------------------------------
// bis_pixel_mem: single-port pixel store
// One access per cycle, write or read; read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module bis_pixel_mem #(
  parameter int DEPTH = 262144,
  parameter int AW    = 18
) (
  input  wire logic                      clk,
  input  wire bis_pkg::pmem_ctl_t        ctl,
  input  wire logic [AW-1:0]             addr,
  input  wire logic [bis_pkg::PIX_W-1:0] wdata,
  output logic      [bis_pkg::PIX_W-1:0] rdata
);

  logic [bis_pkg::PIX_W-1:0] mem [DEPTH];
  logic [bis_pkg::PIX_W-1:0] rdata_r;

  // Write or read the addressed entry
  always_ff @(posedge clk) begin
    if (ctl.en) begin
      if (ctl.we) begin
        mem[addr] <= wdata;
      end else begin
        rdata_r <= mem[addr];
      end
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire
